>>> rtl/swik_pkg.sv
// ----------------------------------------------------------------------------
// swik_pkg
// Types, widths and constants shared by the swerve wheel inverse kinematics.
// ----------------------------------------------------------------------------
package swik_pkg;

	// field widths
	localparam int DIST_W  = 16;
	localparam int SPEED_W = 16;
	localparam int ANG_W   = 16;
	localparam int SPIN_W  = 20;

	// wheel velocity components, Q.20 m/s
	localparam int VEL_W  = 34;
	// cordic vector and angle accumulator (Q.24 rad)
	localparam int CX_W   = 38;
	localparam int Z_W    = 28;
	localparam int ATAN_N = 24;

	// magnitude path
	localparam int ABS_W  = 29;
	localparam int SQ_W   = 58;
	localparam int ROOT_W = SQ_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int DVD_W  = ROOT_W + 4;
	localparam int QUO_W  = SPIN_W;
	localparam int DREM_W = DIST_W + 1;

	// stages of the magnitude path: abs, square, sum, root, divide prep, divide, output
	localparam int MAG_LAT = 3 + ROOT_W + 1 + QUO_W + 1;

	localparam int ANGLE_LIMIT = 25736;
	localparam logic [Z_W-1:0] HALF_PI_Q24 = Z_W'(26353589);
	localparam logic [SPIN_W-1:0] SPIN_MAX = '1;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_FRONT  = 3'd0,
		REG_REAR   = 3'd1,
		REG_LEFT   = 3'd2,
		REG_RIGHT  = 3'd3,
		REG_RADIUS = 3'd4
	} cfg_reg_t;

	typedef logic [1:0] wheel_t;

	localparam wheel_t WHEEL_LAST = 2'd3;

	// geometry registers
	typedef struct packed {
		logic [DIST_W-1:0] front;
		logic [DIST_W-1:0] rear;
		logic [DIST_W-1:0] left;
		logic [DIST_W-1:0] right;
		logic [DIST_W-1:0] radius;
	} geom_t;

	// one wheel job entering the shared pipelines
	typedef struct packed {
		logic                    valid;
		wheel_t                  wheel;
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
	} wheel_job_t;

	// atan(2^-i) in Q.24 radians
	function automatic logic [Z_W-1:0] atan_q24(input int unsigned i);
		logic [Z_W-1:0] r;
		case (i)
			0:       r = Z_W'(13176795);
			1:       r = Z_W'(7778716);
			2:       r = Z_W'(4110060);
			3:       r = Z_W'(2086331);
			4:       r = Z_W'(1047214);
			5:       r = Z_W'(524117);
			6:       r = Z_W'(262123);
			7:       r = Z_W'(131069);
			8:       r = Z_W'(65536);
			9:       r = Z_W'(32768);
			10:      r = Z_W'(16384);
			11:      r = Z_W'(8192);
			12:      r = Z_W'(4096);
			13:      r = Z_W'(2048);
			14:      r = Z_W'(1024);
			15:      r = Z_W'(512);
			16:      r = Z_W'(256);
			17:      r = Z_W'(128);
			18:      r = Z_W'(64);
			19:      r = Z_W'(32);
			20:      r = Z_W'(16);
			21:      r = Z_W'(8);
			22:      r = Z_W'(4);
			23:      r = Z_W'(2);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/swik_issue.sv
// ----------------------------------------------------------------------------
// swik_issue
// Captures a body command, forms the yaw products and issues the four wheel
// velocity vectors, one per cycle.
// ----------------------------------------------------------------------------
module swik_issue import swik_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [SPEED_W-1:0] forward_speed,
	input  logic signed [SPEED_W-1:0] leftward_speed,
	input  logic signed [SPEED_W-1:0] turn_rate,
	input  geom_t                     geom,
	output wheel_job_t                job_s1
);

	localparam int LIN_W  = SPEED_W + 13;
	localparam int PROD_W = SPEED_W + DIST_W + 1;

	logic signed [LIN_W-1:0]  vf_q, vr_q;
	logic signed [PROD_W-1:0] of_q, orr_q, ol_q, ori_q;
	logic [1:0]               cnt_q;
	logic                     active_q;
	logic                     accept;
	logic signed [VEL_W-1:0]  vf_e, vr_e, of_e, orr_e, ol_e, ori_e;
	logic signed [VEL_W-1:0]  vx, vy;

	// the last wheel issues in the same cycle a new command is taken
	assign busy   = active_q && (cnt_q != WHEEL_LAST);
	assign accept = start && !busy;

	// command capture and yaw products
	always_ff @(posedge clk) begin
		if (accept) begin
			vf_q  <= {forward_speed[SPEED_W-1], forward_speed, 12'b0};
			vr_q  <= -$signed({leftward_speed[SPEED_W-1], leftward_speed, 12'b0});
			of_q  <= turn_rate * $signed({1'b0, geom.front});
			orr_q <= turn_rate * $signed({1'b0, geom.rear});
			ol_q  <= turn_rate * $signed({1'b0, geom.left});
			ori_q <= turn_rate * $signed({1'b0, geom.right});
		end
	end

	// wheel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (accept) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (active_q) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == WHEEL_LAST)
				active_q <= 1'b0;
		end
	end

	// wheel vector: bit 1 picks front/rear, bit 0 picks left/right
	always_comb begin
		vf_e  = VEL_W'(vf_q);
		vr_e  = VEL_W'(vr_q);
		of_e  = VEL_W'(of_q);
		orr_e = VEL_W'(orr_q);
		ol_e  = VEL_W'(ol_q);
		ori_e = VEL_W'(ori_q);
		vx    = cnt_q[1] ? (vr_e + orr_e) : (vr_e - of_e);
		vy    = cnt_q[0] ? (vf_e + ori_e) : (vf_e - ol_e);
	end

	// job register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_s1 <= '0;
		end else begin
			job_s1.valid <= active_q;
			job_s1.wheel <= cnt_q;
			job_s1.vx    <= vx;
			job_s1.vy    <= vy;
		end
	end

endmodule

>>> rtl/swik_cordic.sv
// ----------------------------------------------------------------------------
// swik_cordic
// Vectoring cordic, one iteration per stage, giving the steering angle
// atan2(-vx, vy) in Q3.13 radians.
// ----------------------------------------------------------------------------
module swik_cordic import swik_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                    clk,
	input  wheel_job_t              job_s1,
	output logic signed [ANG_W-1:0] angle
);

	localparam int NS = (CORDIC_STAGES > ATAN_N) ? ATAN_N : CORDIC_STAGES;

	logic signed [CX_W-1:0] x_s [0:NS];
	logic signed [CX_W-1:0] y_s [0:NS];
	logic signed [Z_W-1:0]  z_s [0:NS];
	logic                   zero_s [0:NS];
	logic signed [CX_W-1:0] xi, yi;
	logic signed [Z_W-1:0]  zr;

	// pre-rotation into the right half plane
	always_comb begin
		xi = CX_W'(job_s1.vy);
		yi = -CX_W'(job_s1.vx);
	end

	always_ff @(posedge clk) begin
		zero_s[0] <= (xi == '0) && (yi == '0);
		if (xi < 0) begin
			if (yi >= 0) begin
				x_s[0] <= yi;
				y_s[0] <= -xi;
				z_s[0] <= $signed(HALF_PI_Q24);
			end else begin
				x_s[0] <= -yi;
				y_s[0] <= xi;
				z_s[0] <= -$signed(HALF_PI_Q24);
			end
		end else begin
			x_s[0] <= xi;
			y_s[0] <= yi;
			z_s[0] <= '0;
		end
	end

	// micro-rotations
	for (genvar i = 0; i < NS; i++) begin : g_iter
		logic signed [CX_W-1:0] xs, ys;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;
		always_ff @(posedge clk) begin
			zero_s[i+1] <= zero_s[i];
			if (y_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] + ys;
				y_s[i+1] <= y_s[i] - xs;
				z_s[i+1] <= z_s[i] + $signed(atan_q24(i));
			end else begin
				x_s[i+1] <= x_s[i] - ys;
				y_s[i+1] <= y_s[i] + xs;
				z_s[i+1] <= z_s[i] - $signed(atan_q24(i));
			end
		end
	end

	// round to Q3.13 and clamp to +-pi
	assign zr = (z_s[NS] + Z_W'(1024)) >>> 11;

	always_ff @(posedge clk) begin
		if (zero_s[NS])
			angle <= '0;
		else if (zr > ANGLE_LIMIT)
			angle <= ANG_W'(ANGLE_LIMIT);
		else if (zr < -ANGLE_LIMIT)
			angle <= -ANG_W'(ANGLE_LIMIT);
		else
			angle <= ANG_W'(zr);
	end

endmodule

>>> rtl/swik_mag.sv
// ----------------------------------------------------------------------------
// swik_mag
// Wheel speed: floor square root of the squared components, one root bit per
// stage, then a restoring divide by the tire radius, one quotient bit per stage.
// ----------------------------------------------------------------------------
module swik_mag import swik_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  wheel_job_t        job_s1,
	input  logic [DIST_W-1:0] radius,
	output logic              spin_valid,
	output wheel_t            spin_wheel,
	output logic [SPIN_W-1:0] spin
);

	logic signed [VEL_W-1:0] a, b;
	logic [ABS_W-1:0]        ua_s2, ub_s2;
	logic [SQ_W-1:0]         sqa_s3, sqb_s3;
	logic                    v_s2, v_s3;
	wheel_t                  w_s2, w_s3;

	// root pipeline
	logic [SQ_W-1:0]   n_r    [0:ROOT_W];
	logic [REM_W-1:0]  rem_r  [0:ROOT_W];
	logic [ROOT_W-1:0] root_r [0:ROOT_W];
	logic              v_r    [0:ROOT_W];
	wheel_t            w_r    [0:ROOT_W];

	// divide pipeline
	logic [DVD_W-1:0]  dvd_d  [0:QUO_W];
	logic [DREM_W-1:0] rem_d  [0:QUO_W];
	logic [QUO_W-1:0]  quo_d  [0:QUO_W];
	logic              sat_d  [0:QUO_W];
	logic              zero_d [0:QUO_W];
	logic              v_d    [0:QUO_W];
	wheel_t            w_d    [0:QUO_W];

	logic [ROOT_W-1:0] mag;
	logic [DVD_W-1:0]  dvd;

	assign a = job_s1.vx >>> 4;
	assign b = job_s1.vy >>> 4;

	// absolute values
	always_ff @(posedge clk) begin
		ua_s2 <= a[VEL_W-1] ? ABS_W'(-a) : ABS_W'(a);
		ub_s2 <= b[VEL_W-1] ? ABS_W'(-b) : ABS_W'(b);
		w_s2  <= job_s1.wheel;
	end

	// squares, then their sum
	always_ff @(posedge clk) begin
		sqa_s3   <= ua_s2 * ua_s2;
		sqb_s3   <= ub_s2 * ub_s2;
		w_s3     <= w_s2;
		n_r[0]   <= sqa_s3 + sqb_s3;
		rem_r[0] <= '0;
		root_r[0] <= '0;
		w_r[0]   <= w_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_r[0] <= 1'b0;
		end else begin
			v_s2   <= job_s1.valid;
			v_s3   <= v_s2;
			v_r[0] <= v_s3;
		end
	end

	// one root bit per stage
	for (genvar j = 0; j < ROOT_W; j++) begin : g_root
		logic [REM_W-1:0] rem_sh, trial;
		assign rem_sh = {rem_r[j][REM_W-3:0], n_r[j][SQ_W-1 -: 2]};
		assign trial  = {root_r[j], 2'b01};
		always_ff @(posedge clk) begin
			n_r[j+1] <= {n_r[j][SQ_W-3:0], 2'b00};
			w_r[j+1] <= w_r[j];
			if (rem_sh >= trial) begin
				rem_r[j+1]  <= rem_sh - trial;
				root_r[j+1] <= {root_r[j][ROOT_W-2:0], 1'b1};
			end else begin
				rem_r[j+1]  <= rem_sh;
				root_r[j+1] <= {root_r[j][ROOT_W-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_r[j+1] <= 1'b0;
			else
				v_r[j+1] <= v_r[j];
		end
	end

	// divide prep: saturation test and leading remainder
	assign mag = root_r[ROOT_W];
	assign dvd = {mag, 4'b0000};

	always_ff @(posedge clk) begin
		dvd_d[0]  <= dvd;
		rem_d[0]  <= DREM_W'(dvd[DVD_W-1:QUO_W]);
		quo_d[0]  <= '0;
		zero_d[0] <= (mag == '0);
		w_d[0]    <= w_r[ROOT_W];
		if (radius == '0)
			sat_d[0] <= (mag != '0);
		else
			sat_d[0] <= ({(DIST_W + QUO_W - DVD_W)'(0), dvd} >= {radius, QUO_W'(0)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_d[0] <= 1'b0;
		else
			v_d[0] <= v_r[ROOT_W];
	end

	// one quotient bit per stage
	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		logic [DREM_W-1:0] rem_sh;
		assign rem_sh = {rem_d[k][DREM_W-2:0], dvd_d[k][QUO_W-1-k]};
		always_ff @(posedge clk) begin
			dvd_d[k+1]  <= dvd_d[k];
			sat_d[k+1]  <= sat_d[k];
			zero_d[k+1] <= zero_d[k];
			w_d[k+1]    <= w_d[k];
			if (rem_sh >= {1'b0, radius}) begin
				rem_d[k+1] <= rem_sh - {1'b0, radius};
				quo_d[k+1] <= {quo_d[k][QUO_W-2:0], 1'b1};
			end else begin
				rem_d[k+1] <= rem_sh;
				quo_d[k+1] <= {quo_d[k][QUO_W-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_d[k+1] <= 1'b0;
			else
				v_d[k+1] <= v_d[k];
		end
	end

	// output select
	always_ff @(posedge clk) begin
		spin_wheel <= w_d[QUO_W];
		if (zero_d[QUO_W])
			spin <= '0;
		else if (sat_d[QUO_W])
			spin <= SPIN_MAX;
		else
			spin <= quo_d[QUO_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			spin_valid <= 1'b0;
		else
			spin_valid <= v_d[QUO_W];
	end

endmodule

>>> rtl/swerve_wheel_inverse_kinematics.sv
// done is registered from the last wheel's speed, so the root and divide path
// sets its timing (the cordic is shorter for any stage count).
// busy is high after a transfer until the last wheel issues, when a new command
// may be taken; the four wheels share one cordic pipeline and one root/divide
// pipeline, one wheel job per cycle. Results cannot be held off.
// Reset clears control state and loads the default geometry registers.
// ----------------------------------------------------------------------------
// swerve_wheel_inverse_kinematics
// Swerve drive inverse kinematics: steering angle and rotor speed per wheel.
// ----------------------------------------------------------------------------
module swerve_wheel_inverse_kinematics import swik_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [SPEED_W-1:0] forward_speed,
	input  logic signed [SPEED_W-1:0] leftward_speed,
	input  logic signed [SPEED_W-1:0] turn_rate,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [2:0]                cfg_index,
	input  logic [DIST_W-1:0]         cfg_data,
	output logic                      done,
	output logic signed [ANG_W-1:0]   front_left_angle,
	output logic signed [ANG_W-1:0]   front_right_angle,
	output logic signed [ANG_W-1:0]   rear_left_angle,
	output logic signed [ANG_W-1:0]   rear_right_angle,
	output logic [SPIN_W-1:0]         front_left_spin,
	output logic [SPIN_W-1:0]         front_right_spin,
	output logic [SPIN_W-1:0]         rear_left_spin,
	output logic [SPIN_W-1:0]         rear_right_spin
);

	localparam int NS      = (CORDIC_STAGES > ATAN_N) ? ATAN_N : CORDIC_STAGES;
	localparam int ANG_DLY = MAG_LAT - (NS + 2);

	geom_t                   geom_q;
	wheel_job_t              job_s1;
	logic signed [ANG_W-1:0] angle;
	logic                    spin_valid;
	wheel_t                  spin_wheel;
	logic [SPIN_W-1:0]       spin;
	logic signed [ANG_W-1:0] ang_d_q [0:ANG_DLY-1];
	logic signed [ANG_W-1:0] coll_ang_q  [0:2];
	logic [SPIN_W-1:0]       coll_spin_q [0:2];
	logic signed [ANG_W-1:0] ang_out_q  [0:3];
	logic [SPIN_W-1:0]       spin_out_q [0:3];
	logic                    done_q;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.front  <= DIST_W'(2048);
			geom_q.rear   <= DIST_W'(2048);
			geom_q.left   <= DIST_W'(2048);
			geom_q.right  <= DIST_W'(2048);
			geom_q.radius <= DIST_W'(819);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRONT:  geom_q.front  <= cfg_data;
				REG_REAR:   geom_q.rear   <= cfg_data;
				REG_LEFT:   geom_q.left   <= cfg_data;
				REG_RIGHT:  geom_q.right  <= cfg_data;
				REG_RADIUS: geom_q.radius <= cfg_data;
				default:    ;
			endcase
		end
	end

	swik_issue u_issue (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.forward_speed  (forward_speed),
		.leftward_speed (leftward_speed),
		.turn_rate      (turn_rate),
		.geom           (geom_q),
		.job_s1         (job_s1)
	);

	swik_cordic #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk    (clk),
		.job_s1 (job_s1),
		.angle  (angle)
	);

	swik_mag u_mag (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_s1     (job_s1),
		.radius     (geom_q.radius),
		.spin_valid (spin_valid),
		.spin_wheel (spin_wheel),
		.spin       (spin)
	);

	// align angles with the longer speed path
	always_ff @(posedge clk) begin
		ang_d_q[0] <= angle;
		for (int i = 1; i < ANG_DLY; i++)
			ang_d_q[i] <= ang_d_q[i-1];
	end

	// gather the four wheels into one result
	always_ff @(posedge clk) begin
		if (spin_valid) begin
			if (spin_wheel == WHEEL_LAST) begin
				for (int i = 0; i < 3; i++) begin
					ang_out_q[i]  <= coll_ang_q[i];
					spin_out_q[i] <= coll_spin_q[i];
				end
				ang_out_q[3]  <= ang_d_q[ANG_DLY-1];
				spin_out_q[3] <= spin;
			end else begin
				coll_ang_q[spin_wheel]  <= ang_d_q[ANG_DLY-1];
				coll_spin_q[spin_wheel] <= spin;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= spin_valid && (spin_wheel == WHEEL_LAST);
	end

	assign done              = done_q;
	assign front_left_angle  = ang_out_q[0];
	assign front_right_angle = ang_out_q[1];
	assign rear_left_angle   = ang_out_q[2];
	assign rear_right_angle  = ang_out_q[3];
	assign front_left_spin   = spin_out_q[0];
	assign front_right_spin  = spin_out_q[1];
	assign rear_left_spin    = spin_out_q[2];
	assign rear_right_spin   = spin_out_q[3];

endmodule

>>> rtl/swik_checker.sv
// ----------------------------------------------------------------------------
// swik_checker
// Port-level checks on the command handshake, the result strobe and the angle range.
// ----------------------------------------------------------------------------
module swik_checker import swik_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic signed [ANG_W-1:0]   front_left_angle,
	input logic signed [ANG_W-1:0]   rear_right_angle
);

	// a transfer always raises busy for the wheel issue
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low after command transfer");

	// busy only rises from a transfer
	a_busy_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a command transfer");

	// the result strobe is never high on two consecutive cycles
	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe on consecutive cycles");

	// front-left and rear-right angles stay within +-pi when done is high
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (front_left_angle <= ANGLE_LIMIT) && (front_left_angle >= -ANGLE_LIMIT)
			&& (rear_right_angle <= ANGLE_LIMIT) && (rear_right_angle >= -ANGLE_LIMIT))
		else $error("steering angle out of range");

endmodule

bind swerve_wheel_inverse_kinematics swik_checker u_swik_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.front_left_angle (front_left_angle),
	.rear_right_angle (rear_right_angle)
);
